// ===== rtl/core/mcsd_pkg.sv =====
package mcsd_pkg;

  // fixed sizes of the stored state
  localparam int ValueSlots    = 16;
  localparam int SlotW         = $clog2(ValueSlots);
  localparam int ClassCount    = 8;
  localparam int ClassW        = $clog2(ClassCount);
  localparam int MaxDataBytes  = 16;
  localparam int CountW        = 5;
  localparam int ValueW        = 14;

  // configuration register map
  localparam int                AddrW          = 3;
  localparam logic [AddrW-1:0]  AddrEncStep    = 3'd0;
  localparam logic [ValueW-1:0] EncStepReset   = 14'd128;

  // message classes
  localparam logic [ClassW-1:0] ClassButton  = 3'd1;
  localparam logic [ClassW-1:0] ClassEncoder = 3'd3;
  localparam logic [ClassW-1:0] ClassSlider  = 3'd6;

  // button rows
  localparam logic [3:0] RowModeLow  = 4'd2;
  localparam logic [3:0] RowModeHigh = 4'd3;
  localparam logic [3:0] RowZero     = 4'd4;
  localparam logic [3:0] RowSource   = 4'd11;

  localparam logic [6:0]        DataPressed = 7'h7F;
  localparam logic [ValueW-1:0] ValueMax    = 14'd16383;

  // kind of slot write done by a finished message
  typedef enum logic [1:0] {
    WrNone,
    WrZero,
    WrEnc,
    WrSlider
  } wr_kind_e;

  // finished message on its way through the read-modify-write stage
  typedef struct packed {
    logic [ClassW-1:0]  cls;
    logic [3:0]         channel;
    logic [CountW-1:0]  count;
    logic [6:0]         d0;
    logic [6:0]         d1;
    wr_kind_e           kind;
    logic [SlotW-1:0]   slot;
    logic [3:0]         mode;
    logic signed [3:0]  source;
    logic [15:0]        updates;
  } msg_t;

  // result item as held in the output register
  typedef struct packed {
    logic [ClassW-1:0]  cls;
    logic [3:0]         channel;
    logic [CountW-1:0]  count;
    logic [6:0]         d0;
    logic [6:0]         d1;
    logic               unknown;
    logic               written;
    logic [SlotW-1:0]   slot;
    logic [ValueW-1:0]  value;
    logic [3:0]         mode;
    logic signed [3:0]  source;
    logic [15:0]        updates;
  } res_t;

endpackage

// ===== rtl/core/midi_control_surface_decoder.sv =====
// pipeline: a finishing item passes the read-modify-write stage, then the output register;
// throughput: one byte per cycle while in_stall_o is low; the knob value memory is read at
//   accept and written back from the stage, the write forwarded to a later read of that slot
// reset: all control state clears at once; the value memory holds no reset and reads as zero
//   through one valid flag per slot until written, so no clearing pass is needed
module midi_control_surface_decoder import mcsd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // byte input
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               midi_byte_i,
  // result output
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [ClassW-1:0]        msg_class_o,
  output logic [3:0]               msg_channel_o,
  output logic [CountW-1:0]        data_count_o,
  output logic [6:0]               first_data_o,
  output logic [6:0]               second_data_o,
  output logic                     unknown_msg_o,
  output logic                     value_written_o,
  output logic [SlotW-1:0]         value_index_o,
  output logic [ValueW-1:0]        value_after_o,
  output logic [3:0]               mode_now_o,
  output logic signed [3:0]        source_now_o,
  output logic [15:0]              update_total_o,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [AddrW-1:0]         paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  // configuration
  logic [ValueW-1:0] enc_step_q;

  // message assembly state
  logic              open_q, open_d;
  logic [ClassW-1:0] open_cls_q, open_cls_d;
  logic [3:0]        open_ch_q, open_ch_d;
  logic [CountW-1:0] gathered_q, gathered_d;
  logic [6:0]        d0_q, d0_d;
  logic [6:0]        d1_q, d1_d;
  logic [CountW-1:0] cls_len_q [ClassCount];
  logic [3:0]        mode_q, mode_d;
  logic signed [3:0] src_q, src_d;
  logic [15:0]       upd_q, upd_d;

  // finish decision
  logic              accept;
  logic              fin;
  msg_t              fin_msg;
  logic              len_upd;

  // read-modify-write stage
  logic              s1_valid_q;
  msg_t              s1_q;
  logic              s1_go;
  logic [ValueW-1:0] val_mem [ValueSlots];
  logic              slot_valid_q [ValueSlots];
  logic [ValueW-1:0] rd_data_q;
  logic              rd_valid_q;
  logic              fwd_hit_q;
  logic [ValueW-1:0] fwd_val_q;
  logic [ValueW-1:0] old_val;
  logic [ValueW-1:0] new_val;
  logic [ValueW:0]   enc_sum;
  logic              mem_we;

  // output register
  logic              out_valid_q;
  res_t              out_q;

  assign accept     = in_valid_i && !in_stall_o;
  assign s1_go      = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_go;

  // apb register access
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr == AddrEncStep) begin
      prdata = 32'(enc_step_q);
    end
  end

  // byte decode and message finish
  always_comb begin
    logic [CountW-1:0] len;
    logic [3:0]        row;
    logic [2:0]        b;
    open_d     = open_q;
    open_cls_d = open_cls_q;
    open_ch_d  = open_ch_q;
    gathered_d = gathered_q;
    d0_d       = d0_q;
    d1_d       = d1_q;
    mode_d     = mode_q;
    src_d      = src_q;
    upd_d      = upd_q;
    fin        = 1'b0;
    len        = cls_len_q[open_cls_q];
    if (midi_byte_i[7]) begin
      fin        = open_q;
      open_d     = 1'b1;
      open_cls_d = midi_byte_i[6:4];
      open_ch_d  = midi_byte_i[3:0];
      gathered_d = '0;
    end else if (open_q) begin
      if (gathered_q < CountW'(MaxDataBytes)) begin
        if (gathered_q == '0) begin
          d0_d = midi_byte_i[6:0];
        end else if (gathered_q == CountW'(1)) begin
          d1_d = midi_byte_i[6:0];
        end
        gathered_d = gathered_q + CountW'(1);
      end
      if (len != '0 && gathered_d >= len) begin
        fin    = 1'b1;
        open_d = 1'b0;
      end
    end

    // snapshot of the finished message
    fin_msg.cls     = open_cls_q;
    fin_msg.channel = open_ch_q;
    fin_msg.count   = midi_byte_i[7] ? gathered_q : gathered_d;
    fin_msg.d0      = midi_byte_i[7] ? d0_q : d0_d;
    fin_msg.d1      = midi_byte_i[7] ? d1_q : d1_d;
    fin_msg.kind    = WrNone;
    fin_msg.slot    = '0;
    len_upd         = fin_msg.count > len;

    // class actions that need no stored value
    row = fin_msg.d0[6:3];
    b   = fin_msg.d0[2:0];
    if (fin) begin
      case (fin_msg.cls)
        ClassButton: begin
          if ((row == RowModeLow || row == RowModeHigh) && fin_msg.d1 == DataPressed) begin
            mode_d = {row == RowModeHigh, b};
            upd_d  = upd_d + 16'd1;
          end else if (row == RowZero) begin
            fin_msg.kind = WrZero;
            fin_msg.slot = {1'b1, b};
          end else if (row == RowSource) begin
            src_d = $signed({1'b0, b} + 4'd13);
            upd_d = upd_d + 16'd1;
          end
        end
        ClassEncoder: begin
          fin_msg.kind = WrEnc;
          fin_msg.slot = {1'b1, b};
        end
        ClassSlider: begin
          fin_msg.kind = WrSlider;
          fin_msg.slot = open_ch_q;
        end
        default: ;
      endcase
    end
    fin_msg.mode    = mode_d;
    fin_msg.source  = src_d;
    fin_msg.updates = upd_d;
  end

  // new slot contents
  assign old_val = fwd_hit_q ? fwd_val_q : (rd_valid_q ? rd_data_q : '0);
  assign enc_sum = {1'b0, old_val} + {1'b0, enc_step_q};
  always_comb begin
    new_val = '0;
    case (s1_q.kind)
      WrEnc: begin
        if (s1_q.d1[6]) begin
          new_val = (enc_step_q > old_val) ? '0 : old_val - enc_step_q;
        end else begin
          new_val = enc_sum[ValueW] ? ValueMax : enc_sum[ValueW-1:0];
        end
      end
      WrSlider: new_val = {s1_q.d1, s1_q.d0};
      default:  new_val = '0;
    endcase
  end

  assign mem_we = s1_valid_q && s1_go && (s1_q.kind != WrNone);

  // value memory, read at accept and written from the stage after
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      val_mem[s1_q.slot] <= new_val;
    end
    if (accept && fin) begin
      rd_data_q  <= val_mem[fin_msg.slot];
      rd_valid_q <= slot_valid_q[fin_msg.slot];
      fwd_hit_q  <= mem_we && (s1_q.slot == fin_msg.slot);
      fwd_val_q  <= new_val;
      s1_q       <= fin_msg;
    end
    if (s1_valid_q && s1_go) begin
      out_q.cls     <= s1_q.cls;
      out_q.channel <= s1_q.channel;
      out_q.count   <= s1_q.count;
      out_q.d0      <= s1_q.d0;
      out_q.d1      <= s1_q.d1;
      out_q.unknown <= !(s1_q.cls == ClassButton || s1_q.cls == ClassEncoder
                         || s1_q.cls == ClassSlider);
      out_q.written <= s1_q.kind != WrNone;
      out_q.slot    <= s1_q.slot;
      out_q.value   <= new_val;
      out_q.mode    <= s1_q.mode;
      out_q.source  <= s1_q.source;
      out_q.updates <= s1_q.updates;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_step_q  <= EncStepReset;
      open_q      <= 1'b0;
      open_cls_q  <= '0;
      open_ch_q   <= '0;
      gathered_q  <= '0;
      d0_q        <= '0;
      d1_q        <= '0;
      mode_q      <= '0;
      src_q       <= '0;
      upd_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ClassCount; i++) begin
        cls_len_q[i] <= '0;
      end
      for (int i = 0; i < ValueSlots; i++) begin
        slot_valid_q[i] <= 1'b0;
      end
    end else begin
      if (psel && penable && pwrite && pready && paddr == AddrEncStep) begin
        enc_step_q <= pwdata[ValueW-1:0];
      end
      if (accept) begin
        open_q     <= open_d;
        open_cls_q <= open_cls_d;
        open_ch_q  <= open_ch_d;
        gathered_q <= gathered_d;
        d0_q       <= d0_d;
        d1_q       <= d1_d;
        mode_q     <= mode_d;
        src_q      <= src_d;
        upd_q      <= upd_d;
        if (fin && len_upd) begin
          cls_len_q[fin_msg.cls] <= fin_msg.count;
        end
      end
      if (mem_we) begin
        slot_valid_q[s1_q.slot] <= 1'b1;
      end
      if (accept && fin) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_valid_q && s1_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result ports
  assign out_valid_o     = out_valid_q;
  assign msg_class_o     = out_q.cls;
  assign msg_channel_o   = out_q.channel;
  assign data_count_o    = out_q.count;
  assign first_data_o    = out_q.d0;
  assign second_data_o   = out_q.d1;
  assign unknown_msg_o   = out_q.unknown;
  assign value_written_o = out_q.written;
  assign value_index_o   = out_q.slot;
  assign value_after_o   = out_q.value;
  assign mode_now_o      = out_q.mode;
  assign source_now_o    = out_q.source;
  assign update_total_o  = out_q.updates;

endmodule

// ===== tb/midi_control_surface_decoder_tb.sv =====
`timescale 1ns / 1ps

module midi_control_surface_decoder_tb;
  import mcsd_pkg::*;

  // one row of the directed byte table
  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    res_t       want;
  } dir_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [7:0]          midi_byte_i   = 8'h00;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [ClassW-1:0]   msg_class_o;
  logic [3:0]          msg_channel_o;
  logic [CountW-1:0]   data_count_o;
  logic [6:0]          first_data_o;
  logic [6:0]          second_data_o;
  logic                unknown_msg_o;
  logic                value_written_o;
  logic [SlotW-1:0]    value_index_o;
  logic [ValueW-1:0]   value_after_o;
  logic [3:0]          mode_now_o;
  logic signed [3:0]   source_now_o;
  logic [15:0]         update_total_o;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [AddrW-1:0]    paddr         = '0;
  logic [31:0]         pwdata        = '0;
  logic [31:0]         prdata;
  logic                pready;

  // run control shared by the byte sender and the result receiver
  logic                quiet         = 1'b0;
  logic                hold_req      = 1'b0;
  int                  fail_cnt      = 0;
  int                  byte_cnt      = 0;

  // decoder state as the testbench tracks it
  logic [CountW-1:0]   learned_len [ClassCount];
  logic                msg_live;
  logic [ClassW-1:0]   live_cls;
  logic [3:0]          live_ch;
  logic [CountW-1:0]   got_cnt;
  logic [6:0]          byte0;
  logic [6:0]          byte1;
  logic [ValueW-1:0]   slot_val [ValueSlots];
  logic [3:0]          cur_mode;
  logic signed [3:0]   cur_src;
  logic [15:0]         upd_cnt;
  logic [ValueW-1:0]   step_amt;

  res_t                decoded_msgs [$];
  dir_row_t            dir_tab [25];

  midi_control_surface_decoder DUT (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // close the open message: learn its length, apply it, build the result
  function automatic res_t close_message();
    res_t             r;
    logic [3:0]       row;
    logic [2:0]       btn;
    logic [SlotW-1:0] slot;
    int               v;
    int               s;
    if (got_cnt > learned_len[live_cls]) learned_len[live_cls] = got_cnt;
    r = '0;
    r.cls = live_cls;
    r.channel = live_ch;
    r.count = got_cnt;
    r.d0 = byte0;
    r.d1 = byte1;
    row = byte0[6:3];
    btn = byte0[2:0];
    case (live_cls)
      ClassButton: begin
        if ((row == RowModeLow || row == RowModeHigh) && byte1 == DataPressed) begin
          cur_mode = {row == RowModeHigh, btn};
          upd_cnt++;
        end else if (row == RowZero) begin
          slot = {1'b1, btn};
          slot_val[slot] = '0;
          r.written = 1'b1;
          r.slot = slot;
        end else if (row == RowSource) begin
          cur_src = $signed({1'b0, btn}) - 4'sd3;
          upd_cnt++;
        end
      end
      ClassEncoder: begin
        slot = {1'b1, byte0[2:0]};
        v = slot_val[slot];
        s = step_amt;
        // saturating step in either direction
        if (byte1[6]) v = (s > v) ? 0 : v - s;
        else if (s != 0 && s >= 16384 - v) v = ValueMax;
        else v = v + s;
        slot_val[slot] = v[ValueW-1:0];
        r.written = 1'b1;
        r.slot = slot;
        r.value = slot_val[slot];
      end
      ClassSlider: begin
        slot = live_ch;
        slot_val[slot] = {byte1, byte0};
        r.written = 1'b1;
        r.slot = slot;
        r.value = slot_val[slot];
      end
      default: begin
        r.unknown = 1'b1;
      end
    endcase
    r.mode = cur_mode;
    r.source = cur_src;
    r.updates = upd_cnt;
    return r;
  endfunction

  // one accepted byte; returns 1 when it finishes a message
  function automatic bit decode_byte(input logic [7:0] b, output res_t r);
    bit made;
    made = 1'b0;
    r = '0;
    if (b[7]) begin
      if (msg_live) begin
        r = close_message();
        made = 1'b1;
      end
      live_cls = b[6:4];
      live_ch = b[3:0];
      got_cnt = '0;
      msg_live = 1'b1;
      return made;
    end
    if (!msg_live) return 1'b0;
    if (got_cnt < MaxDataBytes) begin
      if (got_cnt == 0) byte0 = b[6:0];
      else if (got_cnt == 1) byte1 = b[6:0];
      got_cnt++;
    end
    if (learned_len[live_cls] != 0 && got_cnt >= learned_len[live_cls]) begin
      r = close_message();
      msg_live = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_cnt++;
    if (fail_cnt <= 200) $display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // compare one received result with the oldest decoded message
  task automatic check_result(input res_t got);
    res_t want;
    if (decoded_msgs.size() == 0) begin
      report_mismatch("unexpected result, class", got.cls, -1);
      return;
    end
    want = decoded_msgs.pop_front();
    if (got.cls !== want.cls) report_mismatch("msg_class", got.cls, want.cls);
    if (got.channel !== want.channel) report_mismatch("msg_channel", got.channel, want.channel);
    if (got.count !== want.count) report_mismatch("data_count", got.count, want.count);
    if (got.d0 !== want.d0) report_mismatch("first_data", got.d0, want.d0);
    if (got.d1 !== want.d1) report_mismatch("second_data", got.d1, want.d1);
    if (got.unknown !== want.unknown) report_mismatch("unknown_msg", got.unknown, want.unknown);
    if (got.written !== want.written) report_mismatch("value_written", got.written, want.written);
    if (got.slot !== want.slot) report_mismatch("value_index", got.slot, want.slot);
    if (got.value !== want.value) report_mismatch("value_after", got.value, want.value);
    if (got.mode !== want.mode) report_mismatch("mode_now", got.mode, want.mode);
    if (got.source !== want.source)
      report_mismatch("source_now", $signed(got.source), $signed(want.source));
    if (got.updates !== want.updates) report_mismatch("update_total", got.updates, want.updates);
  endtask

  // offer one byte, wait for it to be taken, then decode it
  task automatic send_byte(input logic [7:0] b, input bit typed, input res_t want);
    res_t r;
    bit   made;
    while (!quiet && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    midi_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    made = decode_byte(b, r);
    if (typed) decoded_msgs.push_back(want);
    else if (made) decoded_msgs.push_back(r);
    byte_cnt++;
  endtask

  // mostly well-formed messages with random content, some stray bytes
  task automatic send_random_msg();
    logic [2:0] cls;
    logic [3:0] row;
    logic [6:0] d;
    int         n;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_byte(8'($urandom_range(255)), 1'b0, '0);
      return;
    end
    pick = $urandom_range(9);
    cls = (pick < 3) ? ClassButton : (pick < 5) ? ClassEncoder :
          (pick < 7) ? ClassSlider : 3'($urandom_range(7));
    send_byte({1'b1, cls, 4'($urandom_range(15))}, 1'b0, '0);
    n = ($urandom_range(99) < 80) ? 2 : $urandom_range(4);
    for (int k = 0; k < n; k++) begin
      d = 7'($urandom_range(127));
      if (cls == ClassButton && k == 0) begin
        case ($urandom_range(4))
          0: row = RowModeLow;
          1: row = RowModeHigh;
          2: row = RowZero;
          3: row = RowSource;
          default: row = 4'($urandom_range(15));
        endcase
        d = {row, d[2:0]};
      end else if (cls == ClassButton && k == 1 && $urandom_range(1)) begin
        d = DataPressed;
      end
      send_byte({1'b0, d}, 1'b0, '0);
    end
  endtask

  task automatic run_phase(input int n);
    int start;
    start = byte_cnt;
    while (byte_cnt - start < n) send_random_msg();
  endtask

  // drain, then write the encoder step and read it back
  task automatic set_enc_step(input logic [ValueW-1:0] v);
    in_valid_i <= 1'b0;
    while (decoded_msgs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrEncStep;
    pwdata <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    step_amt = v;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata[ValueW-1:0] !== v) report_mismatch("encoder_step readback", prdata[ValueW-1:0], v);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // result receiver: check accepted items, drive stall
  initial begin
    res_t got;
    int   hold_left;
    bit   hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        got = '{msg_class_o, msg_channel_o, data_count_o, first_data_o, second_data_o,
                unknown_msg_o, value_written_o, value_index_o, value_after_o,
                mode_now_o, source_now_o, update_total_o};
        check_result(got);
      end
      // one long hold-off so the pipeline backs up into the input
      if (hold_req && !hold_used) begin
        hold_left = 400;
        hold_used = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < 8);
      end
    end
  end

  // main sequence
  initial begin
    for (int i = 0; i < ClassCount; i++) learned_len[i] = '0;
    for (int i = 0; i < ValueSlots; i++) slot_val[i] = '0;
    msg_live = 1'b0;
    live_cls = '0;
    live_ch = '0;
    got_cnt = '0;
    byte0 = '0;
    byte1 = '0;
    cur_mode = '0;
    cur_src = '0;
    upd_cnt = '0;
    step_amt = EncStepReset;

    // directed bytes: stray data, mode press, encoder clamp, slider extreme,
    // source select, unpressed mode, slot zeroing, unknown class
    dir_tab = '{
      '{8'h05, 1'b0, '0},
      '{8'h90, 1'b0, '0},
      '{8'h15, 1'b0, '0},
      '{8'h7F, 1'b0, '0},
      '{8'hB3, 1'b1, '{ClassButton, 4'd0, 5'd2, 7'h15, DataPressed, 1'b0, 1'b0,
                       4'd0, 14'd0, 4'd5, 4'sd0, 16'd1}},
      '{8'h02, 1'b0, '0},
      '{8'h40, 1'b0, '0},
      '{8'hB3, 1'b1, '{ClassEncoder, 4'd3, 5'd2, 7'h02, 7'h40, 1'b0, 1'b1,
                       4'd10, 14'd0, 4'd5, 4'sd0, 16'd1}},
      '{8'h02, 1'b0, '0},
      '{8'h3F, 1'b0, '0},
      '{8'hE7, 1'b0, '0},
      '{8'h7F, 1'b0, '0},
      '{8'h7F, 1'b0, '0},
      '{8'h9E, 1'b1, '{ClassSlider, 4'd7, 5'd2, 7'h7F, 7'h7F, 1'b0, 1'b1,
                       4'd7, ValueMax, 4'd5, 4'sd0, 16'd1}},
      '{8'h5F, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h91, 1'b0, '0},
      '{8'h1F, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h91, 1'b0, '0},
      '{8'h27, 1'b0, '0},
      '{8'h01, 1'b0, '0},
      '{8'h80, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'hFF, 1'b1, '{3'd0, 4'd0, 5'd1, 7'h00, 7'h01, 1'b1, 1'b0,
                       4'd0, 14'd0, 4'd5, 4'sd4, 16'd2}}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_byte(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].want);

    // overlong message on a class with no learned length, with the long hold-off
    hold_req <= 1'b1;
    repeat (20) send_byte({1'b0, 7'($urandom_range(127))}, 1'b0, '0);
    run_phase(100);

    set_enc_step('0);
    run_phase(100);
    set_enc_step(ValueMax);
    run_phase(100);
    set_enc_step(14'd1);
    run_phase(100);
    set_enc_step(14'($urandom_range(16383)));

    // back-to-back stretch, no idling on either side
    quiet <= 1'b1;
    run_phase(60);
    quiet <= 1'b0;
    run_phase(100);

    // drain and finish
    in_valid_i <= 1'b0;
    while (decoded_msgs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
